FILE: sv/positional_linked_list_macros.svh
// Assertion macros for the positional linked list block.
// Used by the top level; expands to nothing when SYNTHESIS is defined.
`ifndef POSITIONAL_LINKED_LIST_MACROS_SVH
`define POSITIONAL_LINKED_LIST_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk and disabled during rst.
`define PLL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, sampled on clk and disabled during rst.
`define PLL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PLL_ASSERT_NOW(label, ante, cons, msg)
`define PLL_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

FILE: sv/pll_pkg.sv
// Package for the positional linked list: sizes, operation and status codes,
// and the reset link pattern. No dependencies.
`timescale 1ns / 1ps

package pll_pkg;

  // Node store size and derived widths
  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Fixed field widths
  localparam int OP_W     = 3;
  localparam int POS_W    = 8;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  // Width for comparing a position against the count
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [OP_W-1:0] {
    OP_ADD_FRONT    = 3'd0,
    OP_ADD_REAR     = 3'd1,
    OP_REMOVE_FRONT = 3'd2,
    OP_REMOVE_REAR  = 3'd3,
    OP_REMOVE_AT    = 3'd4,
    OP_INSERT_AT    = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_RANGE     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Link held by a node that was never written: the following node, wrapping
  function automatic idx_t next_idx(input idx_t i);
    idx_t r;
    if (i == IDX_W'(CAPACITY - 1)) begin
      r = '0;
    end else begin
      r = i + 1'b1;
    end
    return r;
  endfunction

endpackage

FILE: sv/pll_if.sv
// Valid/ready channel interfaces for the positional linked list:
// the request channel and the result channel. Depends on pll_pkg.
`timescale 1ns / 1ps

interface pll_in_if;
  import pll_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           operation;
  logic [POS_W-1:0]          position;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, operation, position, value, input ready);
  modport sink   (input valid, operation, position, value, output ready);
endinterface

interface pll_out_if;
  import pll_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic signed [VALUE_W-1:0] removed_value;
  logic [COUNT_W-1:0]        element_count;
  logic                      is_empty;

  modport source (output valid, status, removed_value, element_count, is_empty, input ready);
  modport sink   (input valid, status, removed_value, element_count, is_empty, output ready);
endinterface

FILE: sv/positional_linked_list.sv
// Positional linked list top level: link and value memories, free list and the walk
// sequencer. Depends on pll_pkg, pll_if.sv and positional_linked_list_macros.svh.
// Request beat to valid result: a rejected or unused request goes straight to the result;
// 0-based slot 0 or 1 skips the walk, a later slot first walks the links from the head.
// One item at a time: the next request beat is taken once the result has loaded. Reset
// (rst, synchronous): empty list, every link back to its wrap pattern.
`timescale 1ns / 1ps
`include "positional_linked_list_macros.svh"

module positional_linked_list (
  input  logic      clk,
  input  logic      rst,
  pll_in_if.sink    req,
  pll_out_if.source rsp
);
  import pll_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_WALK = 11'b000_0000_0010,
    I_FREE = 11'b000_0000_0100,
    I_PRED = 11'b000_0000_1000,
    I_WR1  = 11'b000_0001_0000,
    I_WR2  = 11'b000_0010_0000,
    R_PRED = 11'b000_0100_0000,
    R_NODE = 11'b000_1000_0000,
    R_WR1  = 11'b001_0000_0000,
    R_WR2  = 11'b010_0000_0000,
    S_DONE = 11'b100_0000_0000
  } state_t;

  // Control state
  state_t state, state_next;
  idx_t   head, tail, free_head;
  cnt_t   held_count;
  logic   out_valid;

  // Per-item working registers
  idx_t                      n_idx, pred, steps_left, free_nxt;
  logic                      k_zero;
  logic                      dec_ins_q;
  logic [VALUE_W-1:0]        value_hold;
  status_t                   status;
  logic [VALUE_W-1:0]        removed;
  logic [STATUS_W-1:0]       out_status;
  logic signed [VALUE_W-1:0] out_removed;
  logic [COUNT_W-1:0]        out_count;
  logic                      out_empty;

  // Link memory with per-entry written flags
  idx_t             link_mem [CAPACITY];
  logic [CAPACITY-1:0] link_vld;
  logic             link_re, link_we;
  idx_t             link_ra, link_wa, link_wd;
  idx_t             link_q, link_ra_q;
  logic             link_vld_q;
  idx_t             link_rd;

  // Value memory
  logic [VALUE_W-1:0] value_mem [CAPACITY];
  logic               val_re, val_we;
  idx_t               val_ra, val_wa;
  logic [VALUE_W-1:0] val_q;

  // Request decode
  logic            acc, out_load, full;
  logic            dec_work, dec_ins;
  cnt_t            dec_k;
  idx_t            dec_steps;
  status_t         dec_status;
  logic [CMP_W-1:0] pos_x, cnt_x;
  idx_t            node_cur;

  assign acc      = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign full     = (held_count == CNT_W'(CAPACITY));
  assign pos_x    = CMP_W'(req.position);
  assign cnt_x    = CMP_W'(held_count);
  assign out_load = (state == S_DONE) && (!out_valid || rsp.ready);
  assign node_cur = k_zero ? n_idx : link_rd;

  // Decode the operation, check range and room, pick the slot
  always_comb begin
    dec_work   = 1'b0;
    dec_ins    = 1'b0;
    dec_k      = '0;
    dec_status = ST_OK;
    case (op_t'(req.operation))
      OP_ADD_FRONT: begin
        if (full) dec_status = ST_FULL;
        else begin dec_work = 1'b1; dec_ins = 1'b1; end
      end
      OP_ADD_REAR: begin
        if (full) dec_status = ST_FULL;
        else begin dec_work = 1'b1; dec_ins = 1'b1; dec_k = held_count; end
      end
      OP_REMOVE_FRONT: begin
        if (held_count == '0) dec_status = ST_UNDERFLOW;
        else dec_work = 1'b1;
      end
      OP_REMOVE_REAR: begin
        if (held_count == '0) dec_status = ST_UNDERFLOW;
        else begin dec_work = 1'b1; dec_k = held_count - 1'b1; end
      end
      OP_REMOVE_AT: begin
        if (pos_x == '0 || pos_x > cnt_x) dec_status = ST_RANGE;
        else begin dec_work = 1'b1; dec_k = CNT_W'(pos_x - CMP_W'(1)); end
      end
      OP_INSERT_AT: begin
        if (pos_x == '0 || pos_x > cnt_x + CMP_W'(1)) dec_status = ST_RANGE;
        else if (full) dec_status = ST_FULL;
        else begin
          dec_work = 1'b1;
          dec_ins  = 1'b1;
          dec_k    = CNT_W'(pos_x - CMP_W'(1));
        end
      end
      default: begin
        dec_status = ST_OK;
      end
    endcase
    dec_steps = IDX_W'(dec_k - CNT_W'(1));
  end

  // Sequence the memory ports and the next state
  always_comb begin
    state_next = state;
    link_re    = 1'b0;
    link_ra    = head;
    link_we    = 1'b0;
    link_wa    = n_idx;
    link_wd    = free_head;
    val_re     = 1'b0;
    val_ra     = node_cur;
    val_we     = 1'b0;
    val_wa     = n_idx;
    case (state)
      S_IDLE: begin
        if (acc) begin
          if (!dec_work) begin
            state_next = S_DONE;
          end else if (dec_k == '0) begin
            state_next = dec_ins ? I_FREE : R_NODE;
          end else if (dec_steps == '0) begin
            state_next = dec_ins ? I_FREE : R_PRED;
          end else begin
            link_re    = 1'b1;
            link_ra    = head;
            state_next = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (steps_left == IDX_W'(1)) begin
          state_next = dec_ins_q ? I_FREE : R_PRED;
        end else begin
          link_re = 1'b1;
          link_ra = link_rd;
        end
      end
      I_FREE: begin
        link_re    = 1'b1;
        link_ra    = free_head;
        state_next = I_PRED;
      end
      I_PRED: begin
        link_re    = !k_zero;
        link_ra    = pred;
        state_next = I_WR1;
      end
      I_WR1: begin
        link_we    = 1'b1;
        link_wa    = n_idx;
        link_wd    = k_zero ? head : link_rd;
        val_we     = 1'b1;
        val_wa     = n_idx;
        state_next = k_zero ? S_DONE : I_WR2;
      end
      I_WR2: begin
        link_we    = 1'b1;
        link_wa    = pred;
        link_wd    = n_idx;
        state_next = S_DONE;
      end
      R_PRED: begin
        link_re    = 1'b1;
        link_ra    = pred;
        state_next = R_NODE;
      end
      R_NODE: begin
        link_re    = 1'b1;
        link_ra    = node_cur;
        val_re     = 1'b1;
        val_ra     = node_cur;
        state_next = R_WR1;
      end
      R_WR1: begin
        link_we = 1'b1;
        if (k_zero) begin
          link_wa    = n_idx;
          link_wd    = free_head;
          state_next = S_DONE;
        end else begin
          link_wa    = pred;
          link_wd    = link_rd;
          state_next = R_WR2;
        end
      end
      R_WR2: begin
        link_we    = 1'b1;
        link_wa    = n_idx;
        link_wd    = free_head;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Link memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    if (link_re) begin
      link_q     <= link_mem[link_ra];
      link_vld_q <= link_vld[link_ra];
      link_ra_q  <= link_ra;
    end
  end

  // Track which link entries were written since reset
  always_ff @(posedge clk) begin
    if (rst) begin
      link_vld <= '0;
    end else if (link_we) begin
      link_vld[link_wa] <= 1'b1;
    end
  end

  // An unwritten link reads as its reset pattern
  assign link_rd = link_vld_q ? link_q : next_idx(link_ra_q);

  // Value memory
  always_ff @(posedge clk) begin
    if (val_we) value_mem[val_wa] <= value_hold;
    if (val_re) val_q <= value_mem[val_ra];
  end

  // Control registers: list pointers, count, state, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      tail       <= '0;
      free_head  <= '0;
      held_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
      case (state)
        I_WR1: begin
          free_head <= free_nxt;
          if (k_zero) begin
            head <= n_idx;
            if (held_count == '0) tail <= n_idx;
            held_count <= held_count + 1'b1;
          end
        end
        I_WR2: begin
          if (pred == tail) tail <= n_idx;
          held_count <= held_count + 1'b1;
        end
        R_WR1: begin
          if (k_zero) begin
            if (held_count == CNT_W'(1)) begin
              head <= '0;
              tail <= '0;
            end else begin
              head <= link_rd;
            end
            free_head  <= n_idx;
            held_count <= held_count - 1'b1;
          end else if (n_idx == tail) begin
            tail <= pred;
          end
        end
        R_WR2: begin
          free_head  <= n_idx;
          held_count <= held_count - 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Working registers and the result register
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (acc) begin
          status     <= dec_status;
          removed    <= '0;
          value_hold <= req.value;
          k_zero     <= (dec_k == '0);
          dec_ins_q  <= dec_ins;
          n_idx      <= head;
          pred       <= head;
          steps_left <= dec_steps;
        end
      end
      S_WALK: begin
        steps_left <= steps_left - 1'b1;
        if (steps_left == IDX_W'(1)) pred <= link_rd;
      end
      I_FREE: n_idx <= free_head;
      I_PRED: free_nxt <= link_rd;
      R_NODE: n_idx <= node_cur;
      R_WR1:  removed <= val_q;
      default: begin
      end
    endcase
    if (out_load) begin
      out_status  <= status;
      out_removed <= removed;
      out_count   <= COUNT_W'(held_count);
      out_empty   <= (held_count == '0);
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.removed_value = out_removed;
  assign rsp.element_count = out_count;
  assign rsp.is_empty      = out_empty;

  // Checks on list bookkeeping and the walk
  `PLL_ASSERT_NOW(a_count_bound, 1'b1, held_count <= CNT_W'(CAPACITY), "count above capacity")
  `PLL_ASSERT_NOW(a_empty_ptrs, state == S_IDLE && held_count == '0, head == '0 && tail == '0, "empty list with stale head or tail")
  `PLL_ASSERT_NOW(a_free_apart, state == S_IDLE && held_count != '0 && held_count != CNT_W'(CAPACITY), free_head != head && free_head != tail, "free head inside the list")
  `PLL_ASSERT_NOW(a_walk_steps, state == S_WALK, steps_left != '0, "walk with no steps left")
  `PLL_ASSERT_NEXT(a_walk_exit, state == S_WALK && steps_left == IDX_W'(1), state == I_FREE || state == R_PRED, "walk did not hand off")

endmodule

FILE: tb/sv/positional_linked_list_test.sv
// Self-checking testbench for the positional linked list block.
// Drives request beats, predicts each result from a value queue, checks every field.
// Depends on pll_pkg, pll_if.sv and the positional_linked_list top level.
`timescale 1ns / 1ps

module positional_linked_list_test;
  import pll_pkg::*;

  // Operation codes outside the decoded set; the block must leave the list alone
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 80;
  localparam int PRINT_LIMIT   = 40;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  removed_value;
    logic [COUNT_W-1:0]  element_count;
    logic                is_empty;
  } list_result_t;

  logic clk;
  logic rst;
  logic take_result = 1'b0;

  pll_in_if  req ();
  pll_out_if rsp ();

  assign rsp.ready = take_result;

  positional_linked_list u_top (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Predicted list contents, head first
  logic [VALUE_W-1:0] held_values[$];
  list_result_t       pending_results[$];

  int error_count = 0;
  int cycle_count = 0;
  int stall_left  = 0;
  bit no_idle     = 1'b0;
  bit growing     = 1'b1;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Count cycles for the watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("positional_linked_list_test: done, errors");
    $finish;
  end

  // Apply one operation to the predicted list and return the result it causes
  function automatic list_result_t apply_list_op(input logic [OP_W-1:0] op,
                                                 input logic [POS_W-1:0] pos,
                                                 input logic [VALUE_W-1:0] val);
    list_result_t r;
    int n;
    int p;
    r.status        = ST_OK;
    r.removed_value = '0;
    n = held_values.size();
    p = int'(pos);
    case (op)
      OP_ADD_FRONT: begin
        if (n >= CAPACITY) r.status = ST_FULL;
        else held_values.push_front(val);
      end
      OP_ADD_REAR: begin
        if (n >= CAPACITY) r.status = ST_FULL;
        else held_values.push_back(val);
      end
      OP_REMOVE_FRONT: begin
        if (n == 0) r.status = ST_UNDERFLOW;
        else r.removed_value = held_values.pop_front();
      end
      OP_REMOVE_REAR: begin
        if (n == 0) r.status = ST_UNDERFLOW;
        else r.removed_value = held_values.pop_back();
      end
      OP_REMOVE_AT: begin
        if (p < 1 || p > n) begin
          r.status = ST_RANGE;
        end else begin
          r.removed_value = held_values[p-1];
          held_values.delete(p - 1);
        end
      end
      OP_INSERT_AT: begin
        // range is checked ahead of room
        if (p < 1 || p > n + 1) r.status = ST_RANGE;
        else if (n >= CAPACITY) r.status = ST_FULL;
        else held_values.insert(p - 1, val);
      end
      default: ;
    endcase
    r.element_count = COUNT_W'(held_values.size());
    r.is_empty      = (held_values.size() == 0);
    return r;
  endfunction

  task automatic report(input string what, input logic [VALUE_W-1:0] got,
                        input logic [VALUE_W-1:0] want);
    error_count++;
    if (error_count <= PRINT_LIMIT)
      $display("%0t mismatch %s: got %0h, want %0h", $realtime, what, got, want);
  endtask

  // Compare one result beat with the oldest prediction
  task automatic check_result();
    list_result_t want;
    if (pending_results.size() == 0) begin
      report("unexpected result beat", VALUE_W'(rsp.element_count), '0);
    end else begin
      want = pending_results.pop_front();
      if (rsp.status !== want.status)
        report("status", VALUE_W'(rsp.status), VALUE_W'(want.status));
      if (rsp.removed_value !== want.removed_value)
        report("removed_value", rsp.removed_value, want.removed_value);
      if (rsp.element_count !== want.element_count)
        report("element_count", VALUE_W'(rsp.element_count), VALUE_W'(want.element_count));
      if (rsp.is_empty !== want.is_empty)
        report("is_empty", VALUE_W'(rsp.is_empty), VALUE_W'(want.is_empty));
    end
  endtask

  // Take result beats; stall in random bursts unless idling is off
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) check_result();
    if (rst) begin
      take_result <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      take_result <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 10);
      take_result <= 1'b0;
    end else begin
      take_result <= 1'b1;
    end
  end

  // Send one request beat, idle first at random, predict once it is accepted
  task automatic send_item(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                           input logic [VALUE_W-1:0] val);
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    req.valid     <= 1'b1;
    req.operation <= op;
    req.position  <= pos;
    req.value     <= val;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    pending_results.push_back(apply_list_op(op, pos, val));
  endtask

  // Drop valid and hold off until every predicted result has come back
  task automatic wait_all_results();
    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [OP_W-1:0] pick_insert_op();
    case ($urandom_range(0, 2))
      0:       return OP_ADD_FRONT;
      1:       return OP_ADD_REAR;
      default: return OP_INSERT_AT;
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_removal_op();
    case ($urandom_range(0, 3))
      0:       return OP_REMOVE_FRONT;
      1:       return OP_REMOVE_REAR;
      default: return OP_REMOVE_AT;
    endcase
  endfunction

  // Mostly an in-range position for the current list, sometimes any byte
  function automatic logic [POS_W-1:0] aim_position(input logic [OP_W-1:0] op);
    int n;
    n = held_values.size();
    if ($urandom_range(0, 7) == 0) return POS_W'($urandom_range(0, 255));
    if (op == OP_INSERT_AT) return POS_W'($urandom_range(1, n + 1));
    if (op == OP_REMOVE_AT && n > 0) return POS_W'($urandom_range(1, n));
    return POS_W'($urandom_range(0, 255));
  endfunction

  // Mixed traffic; the count drifts up to near full and back down to near empty
  task automatic send_mixed(input int items);
    int k;
    int n;
    int pick;
    logic [OP_W-1:0] op;
    for (k = 0; k < items; k++) begin
      n = held_values.size();
      if (n >= CAPACITY - $urandom_range(0, 4)) growing = 1'b0;
      else if (n <= $urandom_range(0, 3)) growing = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 3) op = pick[0] ? OP_UNUSED_HI : OP_UNUSED_LO;
      else if ((pick < 63) == growing) op = pick_insert_op();
      else op = pick_removal_op();
      send_item(op, aim_position(op), $urandom);
    end
  endtask

  // Empty-list errors, range edges, spare codes and value extremes
  task automatic test_directed();
    send_item(OP_REMOVE_FRONT, 8'd0, '0);
    send_item(OP_REMOVE_REAR, 8'd0, '0);
    send_item(OP_REMOVE_AT, 8'd1, '0);
    send_item(OP_INSERT_AT, 8'd0, 32'h1234_5678);
    send_item(OP_INSERT_AT, 8'd2, 32'h1234_5678);
    send_item(OP_UNUSED_LO, 8'd0, '0);
    send_item(OP_UNUSED_HI, 8'd0, '0);
    send_item(OP_INSERT_AT, 8'd1, 32'h8000_0000);
    send_item(OP_ADD_FRONT, 8'd0, 32'h7FFF_FFFF);
    send_item(OP_ADD_REAR, 8'd0, 32'hFFFF_FFFF);
    send_item(OP_ADD_REAR, 8'd0, 32'h0000_0000);
    send_item(OP_INSERT_AT, 8'd5, 32'h0000_0001);
    send_item(OP_INSERT_AT, 8'd3, 32'hA5A5_5A5A);
    send_item(OP_REMOVE_AT, 8'd255, '0);
    send_item(OP_INSERT_AT, 8'd255, 32'h5A5A_A5A5);
    send_item(OP_REMOVE_AT, 8'd7, '0);
    send_item(OP_UNUSED_HI, 8'd255, 32'hFFFF_FFFF);
    send_item(OP_REMOVE_AT, 8'd6, '0);
    send_item(OP_REMOVE_AT, 8'd1, '0);
    send_item(OP_REMOVE_AT, 8'd2, '0);
    send_item(OP_REMOVE_REAR, 8'd0, '0);
    send_item(OP_REMOVE_FRONT, 8'd0, '0);
    send_item(OP_REMOVE_REAR, 8'd0, '0);
    send_item(OP_ADD_REAR, 8'd0, 32'h0000_0005);
    send_item(OP_REMOVE_FRONT, 8'd0, '0);
  endtask

  // Fill to capacity, hit the full and range checks there, then drain
  task automatic test_full_list();
    logic [OP_W-1:0] op;
    while (held_values.size() < CAPACITY) begin
      op = pick_insert_op();
      send_item(op, aim_position(op), $urandom);
    end
    send_item(OP_ADD_FRONT, 8'd0, $urandom);
    send_item(OP_ADD_REAR, 8'd0, $urandom);
    send_item(OP_INSERT_AT, POS_W'(CAPACITY + 1), $urandom);
    send_item(OP_INSERT_AT, POS_W'(CAPACITY + 2), $urandom);
    send_item(OP_INSERT_AT, 8'd0, $urandom);
    send_item(OP_REMOVE_AT, POS_W'(CAPACITY + 1), $urandom);
    send_item(OP_REMOVE_AT, POS_W'(CAPACITY), $urandom);
    send_item(OP_INSERT_AT, POS_W'(CAPACITY), $urandom);
    send_item(OP_REMOVE_REAR, 8'd0, $urandom);
    wait_all_results();
    while (held_values.size() > 0) begin
      op = pick_removal_op();
      send_item(op, aim_position(op), $urandom);
    end
    send_item(OP_REMOVE_REAR, 8'd0, $urandom);
  endtask

  task automatic test_random_mix();
    send_mixed(240);
    wait_all_results();
    send_mixed(240);
  endtask

  // Close with no idling on either side
  task automatic test_back_to_back();
    no_idle = 1'b1;
    send_mixed(100);
  endtask

  initial begin : stimulus
    req.valid     = 1'b0;
    req.operation = OP_ADD_FRONT;
    req.position  = '0;
    req.value     = '0;
    rst           = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    wait_all_results();
    test_full_list();
    wait_all_results();
    test_random_mix();
    test_back_to_back();

    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("positional_linked_list_test: done, clean");
    end else begin
      $display("positional_linked_list_test: done, errors");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/pll_pkg.sv
sv/pll_if.sv
sv/positional_linked_list.sv
tb/sv/positional_linked_list_test.sv
